FILE: design/periodic_task_tick_scheduler_assert.svh
// assertion macros for the periodic task tick scheduler
// both sample on i_clk and are switched off while i_rst_n is low
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PTTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

FILE: design/ptts_pkg.sv
`timescale 1ns / 1ps
package ptts_pkg;

    localparam int MODE_W    = 2;
    localparam int PERIOD_W  = 16;
    localparam int TSTATE_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 3;
    localparam int TICK_W    = 16;

    // input word: task_valid, period, initial_state, comm_ready
    localparam int IN_VALID_LSB  = 0;
    localparam int IN_PERIOD_LSB = 1;
    localparam int IN_INIT_LSB   = IN_PERIOD_LSB + PERIOD_W;
    localparam int IN_COMM_LSB   = IN_INIT_LSB + TSTATE_W;
    localparam int IN_DATA_W     = 24;

    // output word: status, slot_index
    localparam int OUT_SLOT_LSB  = STATUS_W;
    localparam int OUT_DATA_W    = 8;

    // table entry: period, state, tick counter
    localparam int WORD_STATE_LSB = PERIOD_W;
    localparam int WORD_TICK_LSB  = PERIOD_W + TSTATE_W;
    localparam int WORD_W         = PERIOD_W + TSTATE_W + TICK_W;

    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXEC   = 2'd2;

    localparam logic [TSTATE_W-1:0] TS_READY     = 2'd0;
    localparam logic [TSTATE_W-1:0] TS_BLOCKED   = 2'd1;
    localparam logic [TSTATE_W-1:0] TS_SUSPENDED = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_PERIOD = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_TICK_SCAN,
        S_EXEC_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;          // latch the word, rewind the slot pointer
        logic rd_count;      // read the slot at the task count
        logic create_commit; // send create result, store task if ok
        logic scan_tick;     // update one slot for a tick
        logic scan_exec;     // check one slot for dispatch
        logic flush;         // send the final execute result
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic last_slot;
        logic need_emit;
        logic out_free;
    } t_sts;

endpackage

FILE: design/ptts_ram.sv
`timescale 1ns / 1ps
module ptts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ptts_ctrl.sv
`timescale 1ns / 1ps
module ptts_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptts_pkg::MODE_W-1:0]   i_mode,
    input  ptts_pkg::t_sts                i_sts,
    output ptts_pkg::t_cmd                o_cmd
);
    import ptts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        s_tready = 1'b0;
        step     = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_CREATE: begin
                            o_cmd.rd_count = 1'b1;
                            n_state        = S_CREATE;
                        end
                        MODE_TICK: begin
                            n_state = i_sts.cnt_zero ? S_IDLE : S_TICK_SCAN;
                        end
                        MODE_EXEC: begin
                            n_state = i_sts.cnt_zero ? S_FLUSH : S_EXEC_SCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CREATE: begin
                // keep the slot word on the read port while the output is busy
                o_cmd.rd_count = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.create_commit = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_TICK_SCAN: begin
                o_cmd.scan_tick = 1'b1;
                if (i_sts.last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC_SCAN: begin
                step            = !i_sts.need_emit || i_sts.out_free;
                o_cmd.scan_exec = step;
                if (step && i_sts.last_slot) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/ptts_dp.sv
`timescale 1ns / 1ps
module ptts_dp #(
    parameter int MAX_TASKS  = 8,
    parameter int MAX_PERIOD = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptts_pkg::t_cmd                    i_cmd,
    output ptts_pkg::t_sts                    o_sts,
    input  logic [ptts_pkg::IN_DATA_W-1:0]    i_item,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ptts_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_user,
    output logic                              o_out_last
);
    import ptts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0]       COUNT_FULL = CW'(MAX_TASKS);
    localparam logic [PERIOD_W-1:0] PERIOD_LIM = PERIOD_W'(MAX_PERIOD);

    // latched input word
    logic                r_task_valid;
    logic [PERIOD_W-1:0] r_period;
    logic [TSTATE_W-1:0] r_init;
    logic                r_comm;

    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_ptr;
    logic                 r_pend_vld;
    logic [IW-1:0]        r_pend_slot;
    logic [MAX_TASKS-1:0] r_tick_vld;

    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_dv;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                r_out_last;

    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   wr_word;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic [IW-1:0]       cnt_idx;
    logic                we;
    logic [PERIOD_W-1:0] rd_period;
    logic [TSTATE_W-1:0] rd_state;
    logic [TICK_W-1:0]   rd_tick;
    logic [TICK_W-1:0]   create_tick;
    logic [TSTATE_W-1:0] tk_state;
    logic [TICK_W-1:0]   tk_tick;
    logic [STATUS_W-1:0] create_status;
    logic                create_ok;
    logic                is_ready;
    logic                need_emit;
    logic                emit;
    logic                out_free;
    logic [STATUS_W-1:0] em_status;
    logic                em_dv;
    logic [SLOT_W-1:0]   em_slot;
    logic                em_last;
    logic [IW+SLOT_W-1:0] pend_ext;
    logic [SLOT_W-1:0]   pend_slot3;

    assign rd_period = rd_word[PERIOD_W-1:0];
    assign rd_state  = rd_word[WORD_STATE_LSB +: TSTATE_W];
    assign rd_tick   = rd_word[WORD_TICK_LSB +: TICK_W];
    assign cnt_idx   = r_count[IW-1:0];

    assign pend_ext   = {{SLOT_W{1'b0}}, r_pend_slot};
    assign pend_slot3 = pend_ext[SLOT_W-1:0];

    always_comb begin
        if (!r_task_valid) begin
            create_status = STAT_NULL;
        end else if (r_count == COUNT_FULL) begin
            create_status = STAT_FULL;
        end else if (r_period > PERIOD_LIM) begin
            create_status = STAT_PERIOD;
        end else begin
            create_status = STAT_OK;
        end
    end
    assign create_ok = (create_status == STAT_OK);

    // a slot never written reads its counter as zero
    assign create_tick = r_tick_vld[cnt_idx] ? rd_tick : '0;

    always_comb begin
        tk_state = rd_state;
        tk_tick  = rd_tick;
        case (rd_state)
            TS_BLOCKED: begin
                if (rd_tick >= rd_period) begin
                    tk_state = TS_READY;
                    tk_tick  = TICK_W'(1);
                end else begin
                    tk_tick = rd_tick + TICK_W'(1);
                end
            end
            TS_SUSPENDED: begin
                if (r_comm) begin
                    tk_state = TS_READY;
                end
            end
            default: tk_state = rd_state;
        endcase
    end

    assign is_ready  = (rd_state == TS_READY);
    assign need_emit = is_ready && r_pend_vld;
    assign out_free  = !r_out_vld || i_out_ready;

    assign we = (i_cmd.create_commit && create_ok) || i_cmd.scan_tick
              || (i_cmd.scan_exec && is_ready);
    assign wr_addr = i_cmd.create_commit ? cnt_idx : r_ptr;

    always_comb begin
        if (i_cmd.create_commit) begin
            wr_word = {create_tick, r_init, r_period};
        end else if (i_cmd.scan_tick) begin
            wr_word = {tk_tick, tk_state, rd_period};
        end else begin
            wr_word = {rd_tick, TS_BLOCKED, rd_period};
        end
    end

    always_comb begin
        if (i_cmd.rd_count) begin
            rd_addr = cnt_idx;
        end else if (i_cmd.load) begin
            rd_addr = '0;
        end else if (i_cmd.scan_tick || i_cmd.scan_exec) begin
            rd_addr = r_ptr + IW'(1);
        end else begin
            rd_addr = r_ptr;
        end
    end

    ptts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    // result word selection; one emitter per cycle at most
    assign emit = i_cmd.create_commit || i_cmd.flush || (i_cmd.scan_exec && need_emit);

    always_comb begin
        em_status = STAT_OK;
        em_dv     = 1'b1;
        em_slot   = pend_slot3;
        em_last   = 1'b0;
        if (i_cmd.create_commit) begin
            em_status = create_status;
            em_dv     = 1'b0;
            em_slot   = '0;
            em_last   = 1'b1;
        end else if (i_cmd.flush) begin
            em_dv   = r_pend_vld;
            em_slot = r_pend_vld ? pend_slot3 : '0;
            em_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_task_valid <= i_item[IN_VALID_LSB];
            r_period     <= i_item[IN_PERIOD_LSB +: PERIOD_W];
            r_init       <= i_item[IN_INIT_LSB +: TSTATE_W];
            r_comm       <= i_item[IN_COMM_LSB];
        end
        if (emit) begin
            r_out_status <= em_status;
            r_out_dv     <= em_dv;
            r_out_slot   <= em_slot;
            r_out_last   <= em_last;
        end
        if (i_cmd.scan_exec && is_ready) begin
            r_pend_slot <= r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ptr      <= '0;
            r_pend_vld <= 1'b0;
            r_tick_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr      <= '0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.scan_tick || i_cmd.scan_exec) begin
                r_ptr <= r_ptr + IW'(1);
                if (i_cmd.scan_exec && is_ready) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (i_cmd.create_commit && create_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (we) begin
                r_tick_vld[wr_addr] <= 1'b1;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.last_slot = ((CW'(r_ptr) + CW'(1)) == r_count);
    assign o_sts.need_emit = need_emit;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {{(OUT_DATA_W - STATUS_W - SLOT_W){1'b0}}, r_out_slot, r_out_status};
    assign o_out_user  = r_out_dv;
    assign o_out_last  = r_out_last;

endmodule

FILE: design/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// periodic task tick scheduler
// s_* takes one command word per handshake: s_tuser selects create, tick or
// execute, s_tdata carries the create and tick operands.
// m_* returns result words: create gives one word with its status, tick gives
// none, execute gives one word per ready task in ascending slot order with
// m_tlast on the final one, or a single empty word when nothing is ready.
// the task table sits in one RAM with one registered read port and one write
// port; tick and execute walk it one slot per cycle (an execute walk holds while
// a due word cannot enter the output register), create reads and writes one slot.
// only one command is taken at a time; the next waits until the last is done.
// s_tready is high only between commands; a finished word waits in the
// output register while the next command is accepted.
// when m_tready is low and a second dispatch word is due, the slot walk holds.
// reset (i_rst_n low, synchronous) empties the table and clears all tick
// counters; there is no clearing pass.
`include "periodic_task_tick_scheduler_assert.svh"
module periodic_task_tick_scheduler #(
    parameter int MAX_TASKS  = 8,
    parameter int MAX_PERIOD = 1000
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // task_valid, period, initial_state, comm_ready, zero pad
    input  logic [ptts_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode
    input  logic [ptts_pkg::MODE_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, slot_index, zero pad
    output logic [ptts_pkg::OUT_DATA_W-1:0]    m_tdata,
    // dispatch_valid
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import ptts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_mode   (s_tuser),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    ptts_dp #(
        .MAX_TASKS  (MAX_TASKS),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (s_tdata),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_data  (m_tdata),
        .o_out_user  (m_tuser),
        .o_out_last  (m_tlast)
    );

    // a dispatch word is only pushed when the output register can take it
    `PTTS_ASSERT_IMPL(a_emit_room, cmd.scan_exec && sts.need_emit, sts.out_free)
    // no table walk while a new command can be taken
    `PTTS_ASSERT_IMPL(a_idle_quiet, s_tready, !(cmd.scan_tick || cmd.scan_exec || cmd.flush || cmd.create_commit))
    // the closing execute word always carries tlast
    `PTTS_ASSERT_NEXT(a_flush_last, cmd.flush, m_tvalid && m_tlast)

endmodule
